// ===== design/spsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Staged power sequencer package
// Shared types, codes, stage tables and beat layouts for the sequencer.
// ----------------------------------------------------------------------------
package spsq_pkg;

	localparam int unsigned ON_STAGES_DEF  = 6;
	localparam int unsigned OFF_STAGES_DEF = 7;

	localparam int unsigned EN_W    = 12;
	localparam int unsigned PG_W    = 11;
	localparam int unsigned DLY_W   = 16;
	localparam int unsigned LONG_W  = 20;
	localparam int unsigned TRY_W   = 8;
	localparam int unsigned STAGE_W = 3;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned S_TDATA_W  = 16;
	localparam int unsigned S_TUSER_W  = 2;
	localparam int unsigned M_TDATA_W  = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_STABLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_WAIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DC_DELAY       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READY_INTERVAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READY_RETRIES  = 3'd6;

	localparam logic [DLY_W-1:0]  CHECK_DELAY_RST    = 16'd100;
	localparam logic [DLY_W-1:0]  CLOCK_STABLE_RST   = 16'd10;
	localparam logic [DLY_W-1:0]  RESET_RELEASE_RST  = 16'd25;
	localparam logic [DLY_W-1:0]  DISCHARGE_WAIT_RST = 16'd100;
	localparam logic [LONG_W-1:0] DC_DELAY_RST       = 20'd5000;
	localparam logic [LONG_W-1:0] READY_INTERVAL_RST = 20'd5000;
	localparam logic [TRY_W-1:0]  READY_RETRIES_RST  = 8'd10;

	// Item kinds
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ON   = 2'd1;
	localparam logic [1:0] MODE_OFF  = 2'd2;

	// Reported status
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_ON_DONE  = 3'd2;
	localparam logic [2:0] ST_ON_FAIL  = 3'd3;
	localparam logic [2:0] ST_OFF_DONE = 3'd4;
	localparam logic [2:0] ST_OFF_FAIL = 3'd5;

	// Stage indexes with special handling
	localparam logic [STAGE_W-1:0] STAGE_ON_CLOCK    = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_ON_ASIC_HI  = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_OFF_FIRST   = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_OFF_ASIC_HI = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_OFF_0V85    = 3'd4;

	// Flag bit positions
	localparam int unsigned F_CARD  = 0;
	localparam int unsigned F_LED   = 1;
	localparam int unsigned F_DC    = 2;
	localparam int unsigned F_DCDLY = 3;
	localparam int unsigned F_READY = 4;
	localparam int unsigned F_VRMON = 5;
	localparam int unsigned F_MUXP  = 6;
	localparam int unsigned F_MUXD  = 7;

	// Timer run bits
	localparam int unsigned T_RST = 0;
	localparam int unsigned T_DC  = 1;
	localparam int unsigned T_RDY = 2;

	// Reset line bits
	localparam int unsigned RST_SYS = 0;
	localparam int unsigned RST_POR = 1;

	localparam logic [EN_W-1:0] EN_0V85 = 12'h008;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ON,
		PH_OFF,
		PH_DISCH,
		PH_ON_DONE,
		PH_ON_FAIL,
		PH_OFF_DONE,
		PH_OFF_FAIL
	} phase_t;

	typedef struct packed {
		logic [1:0]      mode;
		logic [PG_W-1:0] power_good;
		logic            rail_discharged;
		logic            heartbeat_ok;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]      seq_status;
		logic            device_ready;
		logic            dc_on_delayed;
		logic            dc_on;
		logic            vr_monitor_on;
		logic [1:0]      mux_select;
		logic            power_led;
		logic            card_power_ok;
		logic [1:0]      reset_lines;
		logic [EN_W-1:0] rail_enables;
	} result_t;

	function automatic logic [EN_W-1:0] on_set_mask(input logic [STAGE_W-1:0] s);
		logic [EN_W-1:0] m;
		case (s)
			3'd0:    m = 12'h001;
			3'd1:    m = 12'h00E;
			3'd2:    m = 12'h030;
			3'd3:    m = 12'h0C0;
			3'd4:    m = 12'h300;
			3'd5:    m = 12'hC00;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic on_pass(input logic [STAGE_W-1:0] s, input logic [PG_W-1:0] pg);
		logic ok;
		case (s)
			3'd0:    ok = 1'b1;
			3'd1:    ok = (pg & 11'h007) == 11'h007;
			3'd2:    ok = (pg & 11'h018) == 11'h018;
			3'd3:    ok = (pg & 11'h060) == 11'h060;
			3'd4:    ok = (pg & 11'h180) == 11'h180;
			3'd5:    ok = (pg & 11'h600) == 11'h600;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [EN_W-1:0] off_clear_mask(input logic [STAGE_W-1:0] s);
		logic [EN_W-1:0] m;
		case (s)
			3'd0:    m = 12'hC00;
			3'd1:    m = 12'h300;
			3'd2:    m = 12'h0C0;
			3'd3:    m = 12'h034;
			3'd4:    m = 12'h008;
			3'd5:    m = 12'h002;
			3'd6:    m = 12'h001;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic off_pass(input logic [STAGE_W-1:0] s, input logic [PG_W-1:0] pg);
		logic ok;
		case (s)
			3'd0:    ok = (pg & 11'h600) == '0;
			3'd1:    ok = (pg & 11'h180) == '0;
			3'd2:    ok = (pg & 11'h060) == '0;
			3'd3:    ok = (pg & 11'h01A) == '0;
			3'd4:    ok = (pg & 11'h004) == '0;
			3'd5:    ok = (pg & 11'h001) == '0;
			3'd6:    ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== design/spsq_in_stage.sv =====
// ----------------------------------------------------------------------------
// Sequencer input stage
// Registers one input beat and unpacks it for the sequencer core.
// ----------------------------------------------------------------------------
module spsq_in_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [spsq_pkg::S_TDATA_W-1:0]   s_tdata,  // power_good, rail_discharged, heartbeat_ok
	input  logic [spsq_pkg::S_TUSER_W-1:0]   s_tuser,  // mode
	input  logic                             take,
	output logic                             beat_valid,
	output spsq_pkg::in_beat_t               beat
);
	import spsq_pkg::*;

	logic     valid_q;
	in_beat_t beat_s1;
	logic     load;

	assign s_tready   = !valid_q || take;
	assign load       = s_tvalid && s_tready;
	assign beat_valid = valid_q;
	assign beat       = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1.mode            <= s_tuser[1:0];
			beat_s1.power_good      <= s_tdata[PG_W-1:0];
			beat_s1.rail_discharged <= s_tdata[PG_W];
			beat_s1.heartbeat_ok    <= s_tdata[PG_W+1];
		end
	end

endmodule

// ===== design/spsq_core.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Holds configuration and sequencer state; updates the state once per beat and the configuration on each write.
// ----------------------------------------------------------------------------
module spsq_core #(
	parameter int unsigned ON_STAGES  = spsq_pkg::ON_STAGES_DEF,
	parameter int unsigned OFF_STAGES = spsq_pkg::OFF_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spsq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spsq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              step,
	input  spsq_pkg::in_beat_t                beat,
	output spsq_pkg::result_t                 res
);
	import spsq_pkg::*;

	// Configuration
	logic [DLY_W-1:0]  check_delay_q, clock_stable_q, reset_release_q, discharge_wait_q;
	logic [LONG_W-1:0] dc_delay_q, ready_interval_q;
	logic [TRY_W-1:0]  ready_retries_q;

	// Sequencer state
	phase_t             phase_q, phase_d;
	logic [STAGE_W-1:0] stage_q, stage_d;
	logic [DLY_W-1:0]   wait_q, wait_d;
	logic [EN_W-1:0]    en_q, en_d;
	logic [1:0]         rst_q, rst_d;
	logic [DLY_W-1:0]   rtmr_q, rtmr_d;
	logic [LONG_W-1:0]  dtmr_q, dtmr_d;
	logic [LONG_W-1:0]  ytmr_q, ytmr_d;
	logic [TRY_W-1:0]   tries_q, tries_d;
	logic [7:0]         flags_q, flags_d;
	logic [2:0]         ton_q, ton_d;

	logic               busy;
	logic               enter_on, enter_off;
	logic [STAGE_W-1:0] enter_stage;
	logic [STAGE_W:0]   next_stage;
	logic [2:0]         status;

	assign busy = (phase_q == PH_ON) || (phase_q == PH_OFF) || (phase_q == PH_DISCH);
	assign next_stage = {1'b0, stage_q} + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_delay_q    <= CHECK_DELAY_RST;
			clock_stable_q   <= CLOCK_STABLE_RST;
			reset_release_q  <= RESET_RELEASE_RST;
			discharge_wait_q <= DISCHARGE_WAIT_RST;
			dc_delay_q       <= DC_DELAY_RST;
			ready_interval_q <= READY_INTERVAL_RST;
			ready_retries_q  <= READY_RETRIES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_DELAY:    check_delay_q    <= cfg_data[DLY_W-1:0];
				REG_CLOCK_STABLE:   clock_stable_q   <= cfg_data[DLY_W-1:0];
				REG_RESET_RELEASE:  reset_release_q  <= cfg_data[DLY_W-1:0];
				REG_DISCHARGE_WAIT: discharge_wait_q <= cfg_data[DLY_W-1:0];
				REG_DC_DELAY:       dc_delay_q       <= cfg_data[LONG_W-1:0];
				REG_READY_INTERVAL: ready_interval_q <= cfg_data[LONG_W-1:0];
				REG_READY_RETRIES:  ready_retries_q  <= cfg_data[TRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state for one beat
	always_comb begin
		phase_d     = phase_q;
		stage_d     = stage_q;
		wait_d      = wait_q;
		en_d        = en_q;
		rst_d       = rst_q;
		rtmr_d      = rtmr_q;
		dtmr_d      = dtmr_q;
		ytmr_d      = ytmr_q;
		tries_d     = tries_q;
		flags_d     = flags_q;
		ton_d       = ton_q;
		enter_on    = 1'b0;
		enter_off   = 1'b0;
		enter_stage = stage_q;

		case (beat.mode)
			MODE_TICK: begin
				if (ton_q[T_RST]) begin
					if (rtmr_q > 16'd1) begin
						rtmr_d = rtmr_q - 16'd1;
					end else begin
						rtmr_d         = '0;
						rst_d[RST_POR] = 1'b1;
						ton_d[T_RST]   = 1'b0;
					end
				end
				if (ton_q[T_DC]) begin
					if (dtmr_q > 20'd1) begin
						dtmr_d = dtmr_q - 20'd1;
					end else begin
						dtmr_d           = '0;
						flags_d[F_DCDLY] = flags_q[F_DC];
						ton_d[T_DC]      = 1'b0;
					end
				end
				if (ton_q[T_RDY]) begin
					if (ytmr_q > 20'd1) begin
						ytmr_d = ytmr_q - 20'd1;
					end else begin
						ytmr_d = '0;
						if (beat.heartbeat_ok) begin
							flags_d[F_READY] = 1'b1;
							flags_d[F_MUXP]  = 1'b1;
							flags_d[F_VRMON] = 1'b1;
							ton_d[T_RDY]     = 1'b0;
						end else begin
							tries_d = tries_q - 8'd1;
							if (tries_d == '0) begin
								ton_d[T_RDY] = 1'b0;
							end else begin
								ytmr_d = ready_interval_q;
							end
						end
					end
				end

				case (phase_q)
					PH_DISCH: begin
						if (wait_q > 16'd1) begin
							wait_d = wait_q - 16'd1;
						end else begin
							en_d    = en_q & ~EN_0V85;
							wait_d  = check_delay_q;
							phase_d = PH_OFF;
						end
					end
					PH_ON: begin
						if (wait_q > 16'd1) begin
							wait_d = wait_q - 16'd1;
						end else begin
							wait_d = '0;
							if (!on_pass(stage_q, beat.power_good)) begin
								phase_d = PH_ON_FAIL;
							end else if (next_stage >= 4'(ON_STAGES)) begin
								flags_d[F_CARD] = 1'b1;
								flags_d[F_LED]  = 1'b1;
								flags_d[F_DC]   = 1'b1;
								dtmr_d          = dc_delay_q;
								ton_d[T_DC]     = 1'b1;
								tries_d         = ready_retries_q;
								if (ready_retries_q != '0) begin
									ytmr_d       = ready_interval_q;
									ton_d[T_RDY] = 1'b1;
								end
								phase_d = PH_ON_DONE;
							end else begin
								stage_d     = next_stage[STAGE_W-1:0];
								enter_on    = 1'b1;
								enter_stage = next_stage[STAGE_W-1:0];
							end
						end
					end
					PH_OFF: begin
						if (wait_q > 16'd1) begin
							wait_d = wait_q - 16'd1;
						end else begin
							wait_d = '0;
							if (!off_pass(stage_q, beat.power_good)) begin
								phase_d = PH_OFF_FAIL;
							end else if (next_stage >= 4'(OFF_STAGES)) begin
								phase_d = PH_OFF_DONE;
							end else begin
								stage_d     = next_stage[STAGE_W-1:0];
								enter_off   = 1'b1;
								enter_stage = next_stage[STAGE_W-1:0];
							end
						end
					end
					default: ;
				endcase
			end
			MODE_ON: begin
				if (!busy && !flags_q[F_DC]) begin
					flags_d[F_MUXP]  = 1'b0;
					flags_d[F_MUXD]  = 1'b0;
					flags_d[F_VRMON] = 1'b0;
					phase_d          = PH_ON;
					stage_d          = STAGE_ON_CLOCK;
					enter_on         = 1'b1;
					enter_stage      = STAGE_ON_CLOCK;
				end
			end
			MODE_OFF: begin
				if (!busy && flags_q[F_DC]) begin
					flags_d[F_CARD]  = 1'b0;
					flags_d[F_LED]   = 1'b0;
					flags_d[F_DC]    = 1'b0;
					flags_d[F_DCDLY] = 1'b0;
					flags_d[F_READY] = 1'b0;
					ton_d[T_DC]      = 1'b0;
					ton_d[T_RDY]     = 1'b0;
					dtmr_d           = '0;
					ytmr_d           = '0;
					phase_d          = PH_OFF;
					stage_d          = STAGE_OFF_FIRST;
					enter_off        = 1'b1;
					enter_stage      = STAGE_OFF_FIRST;
				end
			end
			default: ;
		endcase

		// Stage entry actions
		if (enter_on) begin
			en_d   = en_d | on_set_mask(enter_stage);
			wait_d = (enter_stage == STAGE_ON_CLOCK) ? clock_stable_q : check_delay_q;
			if (enter_stage == STAGE_ON_ASIC_HI) begin
				rtmr_d         = reset_release_q;
				ton_d[T_RST]   = 1'b1;
				rst_d[RST_SYS] = 1'b1;
			end
		end
		if (enter_off) begin
			wait_d = check_delay_q;
			if (enter_stage == STAGE_OFF_0V85 && !beat.rail_discharged) begin
				// hold 0V85 for the discharge wait when 1V8 has not yet bled down
				phase_d = PH_DISCH;
				wait_d  = discharge_wait_q;
			end else begin
				en_d = en_d & ~off_clear_mask(enter_stage);
			end
			if (enter_stage == STAGE_OFF_ASIC_HI) begin
				rst_d = '0;
			end
		end
	end

	// Result for this beat
	always_comb begin
		case (phase_d)
			PH_ON, PH_OFF, PH_DISCH: status = ST_BUSY;
			PH_ON_DONE:              status = ST_ON_DONE;
			PH_ON_FAIL:              status = ST_ON_FAIL;
			PH_OFF_DONE:             status = ST_OFF_DONE;
			PH_OFF_FAIL:             status = ST_OFF_FAIL;
			default:                 status = ST_IDLE;
		endcase
		res.rail_enables  = en_d;
		res.reset_lines   = rst_d;
		res.card_power_ok = flags_d[F_CARD];
		res.power_led     = flags_d[F_LED];
		res.mux_select    = {flags_d[F_MUXD], flags_d[F_MUXP]};
		res.vr_monitor_on = flags_d[F_VRMON];
		res.dc_on         = flags_d[F_DC];
		res.dc_on_delayed = flags_d[F_DCDLY];
		res.device_ready  = flags_d[F_READY];
		res.seq_status    = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			stage_q <= '0;
			wait_q  <= '0;
			en_q    <= '0;
			rst_q   <= '0;
			rtmr_q  <= '0;
			dtmr_q  <= '0;
			ytmr_q  <= '0;
			tries_q <= '0;
			flags_q <= '0;
			ton_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			stage_q <= stage_d;
			wait_q  <= wait_d;
			en_q    <= en_d;
			rst_q   <= rst_d;
			rtmr_q  <= rtmr_d;
			dtmr_q  <= dtmr_d;
			ytmr_q  <= ytmr_d;
			tries_q <= tries_d;
			flags_q <= flags_d;
			ton_q   <= ton_d;
		end
	end

endmodule

// ===== design/spsq_out_stage.sv =====
// ----------------------------------------------------------------------------
// Sequencer output stage
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module spsq_out_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  spsq_pkg::result_t                res,
	output logic                             free,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spsq_pkg::M_TDATA_W-1:0]   m_tdata
);
	import spsq_pkg::*;

	logic    valid_q;
	result_t res_s2;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== design/staged_power_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Staged power sequencer, top level
// Input register, sequencer core and output register on stream ports.
// ----------------------------------------------------------------------------
// Each input beat (a 1 ms tick, a power on request or a power off request)
// yields exactly one result beat with the full output picture. A beat moves
// from the input register through the sequencer core into the output
// register, so the block sustains one beat per clock while the output
// register is free; the only limit is the output register, which stalls
// the input side when the result side stalls. Configuration writes take
// effect on the next clock and should be made while idle.
module staged_power_sequencer_top #(
	parameter int unsigned ON_STAGES  = spsq_pkg::ON_STAGES_DEF,
	parameter int unsigned OFF_STAGES = spsq_pkg::OFF_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [10:0] power_good, [11] rail_discharged, [12] heartbeat_ok
	input  logic [spsq_pkg::S_TDATA_W-1:0]    s_tdata,
	// [1:0] mode
	input  logic [spsq_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] rail_enables, [13:12] reset_lines, [14] card_power_ok, [15] power_led,
	// [17:16] mux_select, [18] vr_monitor_on, [19] dc_on, [20] dc_on_delayed,
	// [21] device_ready, [24:22] seq_status
	output logic [spsq_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [spsq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spsq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import spsq_pkg::*;

	logic     beat_valid;
	in_beat_t beat;
	result_t  res;
	logic     out_free;
	logic     advance;

	// advance a beat only when the output register can take its result
	assign advance = beat_valid && out_free;

	spsq_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.take       (advance),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	spsq_core #(
		.ON_STAGES  (ON_STAGES),
		.OFF_STAGES (OFF_STAGES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.beat      (beat),
		.res       (res)
	);

	spsq_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== design/spsq_checker.sv =====
// ----------------------------------------------------------------------------
// Staged power sequencer port checker
// Watches the result stream for handshake and output consistency.
// ----------------------------------------------------------------------------
module spsq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [spsq_pkg::M_TDATA_W-1:0]   m_tdata
);
	import spsq_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[24:22] <= ST_OFF_FAIL)
		else $error("seq_status out of range");

	// card ok, LED and DC status always move together
	a_dc_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14] == m_tdata[19] && m_tdata[15] == m_tdata[19])
		else $error("card ok, LED and DC on disagree");

	// delayed DC and readiness only while DC is on, and then with the DIMM mux bit clear
	a_dc_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20] || m_tdata[21]) |-> m_tdata[19] && !m_tdata[17])
		else $error("delayed DC or ready without DC on");

endmodule

bind staged_power_sequencer_top spsq_checker u_spsq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
